// ----- rtl/dense_matrix_multiply_top_macros.svh -----
// Assertion macros shared by the dense matrix multiply RTL.
// Plain text macros only; no dependencies.
`ifndef DENSE_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define DENSE_MATRIX_MULTIPLY_TOP_MACROS_SVH

// same-cycle implication
`define DMM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmm: same-cycle check failed");

// next-cycle implication
`define DMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmm: next-cycle check failed");

`endif

// ----- rtl/dmm_pkg.sv -----
// Shared types and constants for the dense matrix multiply block.
// No dependencies.
package dmm_pkg;

   localparam int STORE_SIDE     = 8;
   localparam int IDX_W          = 3;
   localparam int ADDR_W         = 2 * IDX_W;
   localparam int STORE_DEPTH    = STORE_SIDE * STORE_SIDE;
   localparam int VALUE_W        = 32;
   localparam int PROD_W         = 2 * VALUE_W;
   localparam int RND_W          = 48;
   localparam int ACC_W          = 51;
   localparam int FRAC_W         = 16;
   localparam int TDATA_W        = 40;
   localparam int PAD_W          = TDATA_W - VALUE_W - 2 * IDX_W;
   localparam int QUEUE_DEPTH    = 4;
   localparam int PTR_W          = $clog2(QUEUE_DEPTH);
   localparam int DEF_INNER_DIM  = 8;
   localparam int DEF_OUTER_COLS = 8;

   localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [PROD_W-1:0]  ROUND_HALF = 64'sh8000;

   typedef enum logic {
      OP_LOAD_A = 1'b0,
      OP_LOAD_B = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [ADDR_W-1:0]          addr;
      logic signed [VALUE_W-1:0]  value;
      logic                       start;
   } cmd_type;

endpackage

// ----- rtl/dmm_front.sv -----
// Ingress stage: takes request words, classifies them into load commands.
// Depends on dmm_pkg.
module dmm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dmm_pkg::TDATA_W-1:0]   req_tdata,  // row[2:0], col[5:3], value[37:6], zero pad
   input  logic                          req_tuser,  // func: 0 = A, 1 = B
   input  logic                          req_tlast,
   output logic                          cmd_vld,
   input  logic                          cmd_rdy,
   output dmm_pkg::cmd_type              cmd
);

   logic             vld_ff, vld_in;
   dmm_pkg::cmd_type cmd_ff, cmd_in;
   logic             take;

   assign req_tready = !vld_ff || cmd_rdy;
   assign take       = req_tvalid && req_tready;
   assign cmd_vld    = vld_ff;
   assign cmd        = cmd_ff;

   always_comb begin
      cmd_in.op    = req_tuser ? dmm_pkg::OP_LOAD_B : dmm_pkg::OP_LOAD_A;
      cmd_in.addr  = {req_tdata[2:0], req_tdata[5:3]};
      cmd_in.value = signed'(req_tdata[37:6]);
      cmd_in.start = req_tlast;
      if (take) begin
         vld_in = 1'b1;
      end else if (cmd_rdy) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ----- rtl/dmm_queue.sv -----
// Short command queue between the ingress stage and the compute engine.
// Depends on dmm_pkg and the assertion macros.
`include "dense_matrix_multiply_top_macros.svh"
module dmm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_vld,
   output logic             in_rdy,
   input  dmm_pkg::cmd_type in_cmd,
   output logic             out_vld,
   input  logic             out_pop,
   output dmm_pkg::cmd_type out_cmd
);

   dmm_pkg::cmd_type                slot_ff [dmm_pkg::QUEUE_DEPTH];
   logic [dmm_pkg::PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [dmm_pkg::PTR_W:0]         count_ff, count_in;
   logic                            push, pop;

   assign in_rdy  = count_ff != (dmm_pkg::PTR_W + 1)'(dmm_pkg::QUEUE_DEPTH);
   assign out_vld = count_ff != '0;
   assign push    = in_vld && in_rdy;
   assign pop     = out_pop && out_vld;
   assign out_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   `DMM_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, count_ff <= (dmm_pkg::PTR_W + 1)'(dmm_pkg::QUEUE_DEPTH))

endmodule

// ----- rtl/dmm_back.sv -----
// Compute engine: A/B element stores, multiply-round-accumulate pipeline, result register.
// Depends on dmm_pkg and the assertion macros.
`include "dense_matrix_multiply_top_macros.svh"
module dmm_back #(
   parameter int INNER_DIM  = dmm_pkg::DEF_INNER_DIM,
   parameter int OUTER_COLS = dmm_pkg::DEF_OUTER_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_vld,
   output logic                          q_pop,
   input  dmm_pkg::cmd_type              q_cmd,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dmm_pkg::TDATA_W-1:0]   rsp_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zero pad
   output logic                          rsp_tuser,  // saturated
   output logic                          rsp_tlast
);

   localparam logic [dmm_pkg::IDX_W-1:0] K_LAST = dmm_pkg::IDX_W'(INNER_DIM - 1);
   localparam logic [dmm_pkg::IDX_W-1:0] I_LAST = dmm_pkg::IDX_W'(INNER_DIM - 1);
   localparam logic [dmm_pkg::IDX_W-1:0] J_LAST = dmm_pkg::IDX_W'(OUTER_COLS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_DRAIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [dmm_pkg::IDX_W-1:0]          i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic                               out_vld_ff, out_vld_in;
   logic [dmm_pkg::IDX_W-1:0]          out_row_ff, out_row_in, out_col_ff, out_col_in;
   logic signed [dmm_pkg::VALUE_W-1:0] out_val_ff, out_val_in;
   logic                               out_sat_ff, out_sat_in, out_last_ff, out_last_in;

   logic                               wr_a, wr_b, issue, out_free, pipe_empty, fits;

   logic signed [dmm_pkg::VALUE_W-1:0] mem_a [dmm_pkg::STORE_DEPTH];
   logic signed [dmm_pkg::VALUE_W-1:0] mem_b [dmm_pkg::STORE_DEPTH];
   logic signed [dmm_pkg::VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [dmm_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [dmm_pkg::RND_W-1:0]   rnd_ff, rnd_in;
   logic signed [dmm_pkg::ACC_W-1:0]   acc_ff;
   logic                               rd_vld_ff, prd_vld_ff, rnd_vld_ff;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign pipe_empty = !(rd_vld_ff || prd_vld_ff || rnd_vld_ff);
   assign fits       = (acc_ff[dmm_pkg::ACC_W-1:dmm_pkg::VALUE_W-1] == '0) ||
                       (acc_ff[dmm_pkg::ACC_W-1:dmm_pkg::VALUE_W-1] == '1);

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_val_in  = out_val_ff;
      out_sat_in  = out_sat_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      q_pop       = 1'b0;
      wr_a        = 1'b0;
      wr_b        = 1'b0;
      issue       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_vld) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  dmm_pkg::OP_LOAD_A: wr_a = 1'b1;
                  dmm_pkg::OP_LOAD_B: wr_b = 1'b1;
               endcase
               if (q_cmd.start) begin
                  state_in = S_CALC;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
               end
            end
         end
         S_CALC: begin
            issue = 1'b1;
            if (k_ff == K_LAST) begin
               k_in     = '0;
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (pipe_empty && out_free) begin
               out_vld_in  = 1'b1;
               out_row_in  = i_ff;
               out_col_in  = j_ff;
               out_sat_in  = !fits;
               out_val_in  = fits ? acc_ff[dmm_pkg::VALUE_W-1:0]
                           : (acc_ff[dmm_pkg::ACC_W-1] ? dmm_pkg::Q_MIN : dmm_pkg::Q_MAX);
               out_last_in = (i_ff == I_LAST) && (j_ff == J_LAST);
               if (j_ff == J_LAST) begin
                  j_in = '0;
                  if (i_ff == I_LAST) begin
                     state_in = S_IDLE;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_CALC;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_CALC;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_vld_ff <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         k_ff       <= k_in;
      end
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
      out_val_ff  <= out_val_in;
      out_sat_ff  <= out_sat_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[q_cmd.addr] <= q_cmd.value;
      end
      rd_a_ff <= mem_a[{i_ff, k_ff}];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[q_cmd.addr] <= q_cmd.value;
      end
      rd_b_ff <= mem_b[{k_ff, j_ff}];
   end

   // Q32.32 product, rounded half up to Q32.16
   assign prod_in = dmm_pkg::PROD_W'(rd_a_ff) * dmm_pkg::PROD_W'(rd_b_ff);
   assign rnd_in  = dmm_pkg::RND_W'((prod_ff + dmm_pkg::ROUND_HALF) >>> dmm_pkg::FRAC_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         prd_vld_ff <= 1'b0;
         rnd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= issue;
         prd_vld_ff <= rd_vld_ff;
         rnd_vld_ff <= prd_vld_ff;
      end
      prod_ff <= prod_in;
      rnd_ff  <= rnd_in;
      if (issue && (k_ff == '0)) begin
         acc_ff <= '0;
      end else if (rnd_vld_ff) begin
         acc_ff <= acc_ff + dmm_pkg::ACC_W'(rnd_ff);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{dmm_pkg::PAD_W{1'b0}}, out_val_ff, out_col_ff, out_row_ff};
   assign rsp_tuser  = out_sat_ff;
   assign rsp_tlast  = out_last_ff;

   `DMM_ASSERT_SAME(a_idle_pipe_empty, clock, reset, state_ff == S_IDLE, pipe_empty)
   `DMM_ASSERT_SAME(a_pop_only_idle, clock, reset, q_pop, state_ff == S_IDLE)
   `DMM_ASSERT_NEXT(a_issue_reads, clock, reset, state_ff == S_CALC, rd_vld_ff)

endmodule

// ----- rtl/dense_matrix_multiply_top.sv -----
// Top level of the dense matrix multiply block (C = A x B, signed Q16.16).
// Depends on dmm_pkg, dmm_front, dmm_queue and dmm_back.
//
// Load words carry one element of A (tuser 0) or B (tuser 1) at (row, col) and are taken one
// per cycle while the four-entry command queue has room; while idle, the engine retires one
// load per cycle. The word with tlast is stored, then the engine computes C with a single
// multiply-accumulate unit: for each C element it issues INNER_DIM store reads through the
// read, multiply, round and accumulate stages, and emits the elements row-major with tlast
// on the final word. Loads that arrive during a product queue up and are applied after it.
// Sums outside the Q16.16 range are clipped and flagged on rsp_tuser. Stores have no reset:
// every element a product reads must have been loaded first.
module dense_matrix_multiply_top #(
   parameter int INNER_DIM  = dmm_pkg::DEF_INNER_DIM,
   parameter int OUTER_COLS = dmm_pkg::DEF_OUTER_COLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dmm_pkg::TDATA_W-1:0]   req_tdata,  // row[2:0], col[5:3], value[37:6], zero pad
   input  logic                          req_tuser,  // func
   input  logic                          req_tlast,  // last
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dmm_pkg::TDATA_W-1:0]   rsp_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zero pad
   output logic                          rsp_tuser,  // saturated
   output logic                          rsp_tlast   // out_last
);

   logic             f_vld, f_rdy, q_vld, q_pop;
   dmm_pkg::cmd_type f_cmd, q_cmd;

   dmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_vld    (f_vld),
      .cmd_rdy    (f_rdy),
      .cmd        (f_cmd)
   );

   dmm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (f_vld),
      .in_rdy  (f_rdy),
      .in_cmd  (f_cmd),
      .out_vld (q_vld),
      .out_pop (q_pop),
      .out_cmd (q_cmd)
   );

   dmm_back #(
      .INNER_DIM  (INNER_DIM),
      .OUTER_COLS (OUTER_COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_vld      (q_vld),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
